FILE: rtl/core/pdf_pkg.sv
// shared constants and types for the pareto dominance filter
// no dependencies; used by pdf_cmp and the top level
package pdf_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int MAX_MEASURES = 4;
  localparam int MEAS_W       = 32;
  localparam int POINT_W      = MAX_MEASURES * MEAS_W;
  localparam int SLOT_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_W        = 3;

  typedef logic [MAX_MEASURES-1:0][MEAS_W-1:0] point_t;
  typedef logic [MAX_MEASURES-1:0]             meas_mask_t;

  // outcome of one candidate versus stored point comparison
  typedef struct packed {
    logic cand_no_smaller;    // stored point dominates the candidate
    logic stored_no_smaller;  // candidate dominates the stored point
  } cmp_res_t;

endpackage

FILE: rtl/core/pdf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pdf_cmp.sv
// shared two-way dominance compare of the candidate against one stored point
// depends on pdf_pkg
module pdf_cmp (
  input  pdf_pkg::point_t     cand,
  input  pdf_pkg::point_t     stored,
  input  pdf_pkg::meas_mask_t act_mask,
  output pdf_pkg::cmp_res_t   res
);

  always_comb begin
    res.cand_no_smaller   = 1'b1;
    res.stored_no_smaller = 1'b1;
    for (int i = 0; i < pdf_pkg::MAX_MEASURES; i++) begin
      if (act_mask[i]) begin
        if ($signed(cand[i]) < $signed(stored[i])) begin
          res.cand_no_smaller = 1'b0;
        end
        if ($signed(stored[i]) < $signed(cand[i])) begin
          res.stored_no_smaller = 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/pareto_dominance_filter_top.sv
// top level of the pareto dominance filter: sequencer, slot valid bits, counters
// depends on pdf_pkg, pdf_ram, pdf_cmp
//
// usage:
//   a request is taken at a rising edge with start high and busy low; func
//   and measure_0..measure_3 are sampled then. func 0 only tests whether the
//   candidate is dominated; func 1, if it is not dominated, also removes stored
//   points it dominates and stores the candidate in the lowest free slot, if any.
//   cfg_wr_en / cfg_wr_data set the number of compared measures (reset 2);
//   write it only while busy is low.
//   the result (accepted, removed_count, entry_count, overflow) appears for
//   exactly one cycle with done high, after the scan and the table update.
//   the receiver cannot stall: done is a one-cycle strobe.
//   a request is finished before the next is taken: the scan sends one table
//   slot per cycle through the shared comparator, behind the registered ram
//   read, then the finish state updates the table; busy is low in the cycle done
//   is high, so the next request is taken at the edge that ends that cycle.
//   synchronous reset empties the table and returns the config to 2
//   measures; point storage itself is not cleared, only its valid bits.
module pareto_dominance_filter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic signed [31:0]             measure_0,
  input  logic signed [31:0]             measure_1,
  input  logic signed [31:0]             measure_2,
  input  logic signed [31:0]             measure_3,
  input  logic                           cfg_wr_en,
  input  logic [pdf_pkg::CFG_W-1:0]      cfg_wr_data,
  output logic                           done,
  output logic                           accepted,
  output logic [pdf_pkg::COUNT_W-1:0]    removed_count,
  output logic [pdf_pkg::COUNT_W-1:0]    entry_count,
  output logic                           overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                            state;
  logic [pdf_pkg::COUNT_W-1:0]       cnt;
  pdf_pkg::point_t                   cand;
  logic                              ext;
  pdf_pkg::meas_mask_t               act_mask;
  logic                              dominated;
  logic [pdf_pkg::TABLE_DEPTH-1:0]   rm_mask;
  logic [pdf_pkg::COUNT_W-1:0]       rm_cnt;
  logic [pdf_pkg::TABLE_DEPTH-1:0]   valid;
  logic [pdf_pkg::COUNT_W-1:0]       held;
  logic [pdf_pkg::CFG_W-1:0]         measures_in_use;

  pdf_pkg::meas_mask_t               act_mask_next;
  logic [pdf_pkg::CFG_W-1:0]         eff_n;
  logic [pdf_pkg::POINT_W-1:0]       rdata;
  pdf_pkg::cmp_res_t                 cr;
  logic [pdf_pkg::SLOT_W-1:0]        cmp_slot;
  logic                              do_ext;
  logic [pdf_pkg::TABLE_DEPTH-1:0]   valid_next;
  logic [pdf_pkg::TABLE_DEPTH-1:0]   valid_upd;
  logic                              free_found;
  logic [pdf_pkg::SLOT_W-1:0]        free_slot;
  logic [pdf_pkg::COUNT_W-1:0]       held_next;
  logic                              ram_we;

  assign busy = (state != ST_IDLE);

  // zero counts as one measure, values above the limit saturate
  always_comb begin
    if (measures_in_use == '0) begin
      eff_n = pdf_pkg::CFG_W'(1);
    end else if (measures_in_use > pdf_pkg::CFG_W'(pdf_pkg::MAX_MEASURES)) begin
      eff_n = pdf_pkg::CFG_W'(pdf_pkg::MAX_MEASURES);
    end else begin
      eff_n = measures_in_use;
    end
    for (int i = 0; i < pdf_pkg::MAX_MEASURES; i++) begin
      act_mask_next[i] = (i < int'(eff_n));
    end
  end

  // slot whose data comes out of the ram this cycle
  assign cmp_slot = cnt[pdf_pkg::SLOT_W-1:0] - pdf_pkg::SLOT_W'(1);

  pdf_ram #(
    .WIDTH (pdf_pkg::POINT_W),
    .DEPTH (pdf_pkg::TABLE_DEPTH)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (cand),
    .raddr (cnt[pdf_pkg::SLOT_W-1:0]),
    .rdata (rdata)
  );

  pdf_cmp u_cmp (
    .cand     (cand),
    .stored   (pdf_pkg::point_t'(rdata)),
    .act_mask (act_mask),
    .res      (cr)
  );

  // table update for the finishing item
  always_comb begin
    do_ext     = ext && !dominated;
    valid_next = do_ext ? (valid & ~rm_mask) : valid;
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = pdf_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_next[i]) begin
        free_found = 1'b1;
        free_slot  = pdf_pkg::SLOT_W'(i);
      end
    end
    valid_upd = valid_next;
    if (do_ext && free_found) begin
      valid_upd[free_slot] = 1'b1;
    end
    held_next = held;
    if (do_ext) begin
      held_next = held - rm_cnt + (free_found ? pdf_pkg::COUNT_W'(1) : '0);
    end
    ram_we = (state == ST_FINISH) && do_ext && free_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      valid           <= '0;
      held            <= '0;
      measures_in_use <= pdf_pkg::CFG_W'(2);
      done            <= 1'b0;
      cnt             <= '0;
    end else begin
      if (cfg_wr_en) begin
        measures_in_use <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cand      <= {measure_3, measure_2, measure_1, measure_0};
            ext       <= func;
            act_mask  <= act_mask_next;
            dominated <= 1'b0;
            rm_mask   <= '0;
            rm_cnt    <= '0;
            cnt       <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + pdf_pkg::COUNT_W'(1);
          // first cycle only issues the read of slot 0
          if (cnt != '0 && valid[cmp_slot]) begin
            if (cr.cand_no_smaller) begin
              dominated <= 1'b1;
            end
            if (cr.stored_no_smaller) begin
              rm_mask[cmp_slot] <= 1'b1;
              rm_cnt            <= rm_cnt + pdf_pkg::COUNT_W'(1);
            end
          end
          if (cnt == pdf_pkg::COUNT_W'(pdf_pkg::TABLE_DEPTH)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          valid         <= valid_upd;
          held          <= held_next;
          done          <= 1'b1;
          accepted      <= !dominated;
          removed_count <= do_ext ? rm_cnt : '0;
          entry_count   <= held_next;
          overflow      <= do_ext && !free_found;
          state         <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
